// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the slot allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/tdma_pkg.sv =====
// Types and constants of the TDMA slot allocator.
package tdma_pkg;
	localparam int MAP_W = 16;
	localparam int SLOT_W = 4;
	localparam int ADDR_W = 64;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RANGE = 3'd1;
	localparam logic [2:0] ST_ZERO = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_NOFREE = 3'd4;

	localparam logic ACT_HB = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic action;
		logic [ADDR_W-1:0] sender_addr;
		logic [SLOT_W-1:0] heard_slot;
		logic [MAP_W-1:0] heard_colmap;
		logic [MAP_W-1:0] heard_nbrmap;
		logic [MAP_W-1:0] random_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic send_heartbeat;
		logic [MAP_W-1:0] out_colmap;
		logic [MAP_W-1:0] out_nbrmap;
		logic [SLOT_W-1:0] own_slot;
		logic [SLOT_W-1:0] wait_slots;
	} out_item_t;

	function automatic logic [MAP_W-1:0] slot_bit(input logic [SLOT_W-1:0] s);
		slot_bit = MAP_W'(1) << s;
	endfunction
endpackage

// ===== rtl/tdma_slot_allocator_top.sv =====
// Top level of the TDMA slot allocator: sequencer, neighbor table and slot probe.
//
// One word is processed at a time and the input is not ready meanwhile. From the
// accepting edge to the edge that raises out_valid, a heartbeat with a usable slot
// passes setup, a walk of one table entry per cycle through the registered address
// RAM, the table update and the result; a rejected heartbeat or a tick on an
// inactive node passes only setup and result. An active tick passes setup, the walk
// (own slot first, then the table) and the result, plus the reduction of the random
// start and the probe of candidates (up to 15) when a new slot is needed. The table
// walk and the probe set the rate. A result waits in an output register; the block
// is ready for the next word in the cycle after that result is taken.
module tdma_slot_allocator_top #(
	parameter int MAX_PEERS   = 15,
	parameter int FRAME_SLOTS = 16,
	parameter int PEER_TTL    = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  tdma_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tdma_pkg::out_item_t out_data
);
	import tdma_pkg::*;
	`include "assert_macros.svh"

	localparam int IW = $clog2(MAX_PEERS);
	localparam int CW = $clog2(MAX_PEERS + 1);
	localparam int TW = $clog2(PEER_TTL + 1);
	localparam int SPAN = (FRAME_SLOTS - 1) > 15 ? 15 : (FRAME_SLOTS - 1);
	// reciprocal of SPAN for the probe start: quotient = (rnd * RECIP) >> RSH
	localparam int RL = $clog2(SPAN);
	localparam int RSH = MAP_W + RL;
	localparam logic [MAP_W:0] RECIP =
		(MAP_W + 1)'(((64'd1 << RSH) + 64'(SPAN) - 64'd1) / 64'(SPAN));

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_HBRD  = 8'b00000010,
		S_HBWR  = 8'b00000100,
		S_PROBE = 8'b00001000,
		S_WALK  = 8'b00010000,
		S_OUT   = 8'b00100000,
		S_START = 8'b01000000,
		S_MOD   = 8'b10000000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [TW-1:0] ttl_q [MAX_PEERS];
	logic [SLOT_W-1:0] pslot_q [MAX_PEERS];
	logic [MAP_W-1:0] latched_q, gather_q, ocol_q, onbr_q;
	logic [SLOT_W-1:0] tx_q, cand_q;
	logic coll_q, active_q;
	logic [CW-1:0] idx_q;
	logic [3:0] pcnt_q;
	logic [2:0] status_q;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic out_valid_q;
	out_item_t out_q;
	logic [MAP_W-1:0] quo_q;

	logic ram_we;
	logic [IW-1:0] ram_addr, prev_idx;
	logic [ADDR_W-1:0] ram_rdata;

	tdma_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_PEERS)) u_addr_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(item_q.sender_addr),
		.rdata(ram_rdata)
	);

	// entry whose RAM data is valid this cycle (read issued last cycle)
	assign prev_idx = IW'(idx_q - CW'(1));
	always_comb begin
		ram_we = (state_q == S_HBWR) && (hit_q || free_q);
		ram_addr = (state_q == S_HBWR) ? (hit_q ? hit_idx_q : free_idx_q)
			: ((idx_q < CW'(MAX_PEERS)) ? IW'(idx_q) : '0);
	end

	logic [2*MAP_W:0] prod;
	logic [MAP_W-1:0] rem;
	assign prod = {{(MAP_W + 1){1'b0}}, item_q.random_value} * {{MAP_W{1'b0}}, RECIP};
	assign rem = item_q.random_value - quo_q * MAP_W'(SPAN);

	logic [SLOT_W-1:0] cand_next;
	assign cand_next = (cand_q == SLOT_W'(SPAN)) ? SLOT_W'(1) : cand_q + SLOT_W'(1);
	logic [MAP_W-1:0] wbit;
	assign wbit = slot_bit(pslot_q[prev_idx]);

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < MAX_PEERS; i++) ttl_q[i] <= '0;
			latched_q <= '0; gather_q <= '0; tx_q <= '0;
			coll_q <= 1'b0; active_q <= 1'b0; out_valid_q <= 1'b0;
			idx_q <= '0; pcnt_q <= '0; status_q <= ST_OK;
			hit_q <= 1'b0; free_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
				tx_q <= SLOT_W'(cfg_data);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						status_q <= ST_OK;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (item_q.action == ACT_HB) begin
						active_q <= 1'b1;
						if (32'(item_q.heard_slot) >= FRAME_SLOTS) begin
							status_q <= ST_RANGE; state_q <= S_OUT;
						end else if (item_q.heard_slot == '0) begin
							status_q <= ST_ZERO; state_q <= S_OUT;
						end else begin
							idx_q <= CW'(1); state_q <= S_HBRD;
						end
					end else begin
						latched_q <= gather_q;
						gather_q <= '0;
						quo_q <= MAP_W'(prod >> RSH);
						pcnt_q <= '0;
						ocol_q <= '0;
						if ((tx_q == '0 || coll_q) && active_q) state_q <= S_MOD;
						else state_q <= active_q ? S_WALK : S_OUT;
						if (tx_q == '0 || coll_q) coll_q <= 1'b0;
						// walk seeds the map with the own slot first
						idx_q <= '0;
					end
				end
				S_MOD: begin
					cand_q <= SLOT_W'(rem) + SLOT_W'(1);
					state_q <= S_PROBE;
				end
				S_HBRD: begin
					// check entry prev_idx
					if (ttl_q[prev_idx] != '0) begin
						if (!hit_q && ram_rdata == item_q.sender_addr) begin
							hit_q <= 1'b1; hit_idx_q <= prev_idx;
						end
					end else if (!free_q) begin
						free_q <= 1'b1; free_idx_q <= prev_idx;
					end
					if (idx_q == CW'(MAX_PEERS)) state_q <= S_HBWR;
					else idx_q <= idx_q + CW'(1);
				end
				S_HBWR: begin
					if (hit_q || free_q) begin
						gather_q <= gather_q | item_q.heard_nbrmap;
						if ((item_q.heard_colmap & slot_bit(tx_q)) != '0) coll_q <= 1'b1;
						ttl_q[hit_q ? hit_idx_q : free_idx_q] <= TW'(PEER_TTL);
						pslot_q[hit_q ? hit_idx_q : free_idx_q] <= item_q.heard_slot;
					end else begin
						status_q <= ST_FULL;
					end
					state_q <= S_OUT;
				end
				S_PROBE: begin
					if (cand_q != tx_q && (latched_q & slot_bit(cand_q)) == '0) begin
						tx_q <= cand_q;
						state_q <= S_WALK;
					end else if (pcnt_q == 4'(SPAN - 1)) begin
						status_q <= ST_NOFREE;
						state_q <= S_WALK;
					end else begin
						pcnt_q <= pcnt_q + 4'd1;
						cand_q <= cand_next;
					end
					idx_q <= '0;
				end
				S_WALK: begin
					if (idx_q == '0) begin
						onbr_q <= slot_bit(tx_q);
						idx_q <= CW'(1);
					end else begin
						if (ttl_q[prev_idx] != '0) begin
							if ((onbr_q & wbit) != '0) begin
								if (tx_q != '0 && pslot_q[prev_idx] == tx_q) coll_q <= 1'b1;
								ocol_q <= ocol_q | wbit;
							end
							onbr_q <= onbr_q | wbit;
							ttl_q[prev_idx] <= ttl_q[prev_idx] - TW'(1);
						end
						if (idx_q == CW'(MAX_PEERS)) state_q <= S_OUT;
						else idx_q <= idx_q + CW'(1);
					end
				end
				S_OUT: begin
					out_q.status <= status_q;
					out_q.send_heartbeat <= item_q.action == ACT_TICK && active_q;
					out_q.out_colmap <= (item_q.action == ACT_TICK && active_q) ? ocol_q : '0;
					out_q.out_nbrmap <= (item_q.action == ACT_TICK && active_q) ? onbr_q : '0;
					out_q.own_slot <= tx_q;
					out_q.wait_slots <= (coll_q || tx_q == '0) ? '0 : tx_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !in_ready)
	`ASSERT_NEXT(a_out_after_done, clk, arst_n, state_q == S_OUT, out_valid_q)
	`ASSERT_IMPL(a_write_in_hbwr, clk, arst_n, ram_we, state_q == S_HBWR)
endmodule

// ===== rtl/tdma_ram.sv =====
// Generic single-port RAM with registered read.
module tdma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
